// ----- rtl/dmsp_pkg.sv -----
// Shared types and character codes for the DMS angle text parser.
`timescale 1ns / 1ps

package dmsp_pkg;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_DEG  = 3'd0,
        PH_MIN  = 3'd1,
        PH_SEC  = 3'd2,
        PH_FRAC = 3'd3,
        PH_DONE = 3'd4,
        PH_FAIL = 3'd5
    } t_phase;

    typedef struct packed {
        logic        valid_res;
        logic        negative;
        logic [15:0] degrees;
        logic [15:0] minutes;
        logic [15:0] seconds;
        logic [29:0] fraction;
        logic [3:0]  fraction_digits;
        logic        overflow;
    } t_result;

endpackage

// ----- rtl/dmsp_if.sv -----
// Input and result channel interfaces for the DMS angle text parser.
`timescale 1ns / 1ps

interface dmsp_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface dmsp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic        negative;
    logic [15:0] degrees;
    logic [15:0] minutes;
    logic [15:0] seconds;
    logic [29:0] fraction;
    logic [3:0]  fraction_digits;
    logic        overflow;

    modport source (
        output valid, output valid_res, output negative, output degrees,
        output minutes, output seconds, output fraction,
        output fraction_digits, output overflow, input ready
    );
    modport sink (
        input valid, input valid_res, input negative, input degrees,
        input minutes, input seconds, input fraction,
        input fraction_digits, input overflow, output ready
    );
endinterface

// ----- rtl/dmsp_core.sv -----
// Parser state and per-character update logic for the DMS angle text parser.
`timescale 1ns / 1ps

module dmsp_core #(
    parameter int FIELD_BITS      = 16,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step_valid,
    input  logic              i_opcode,
    input  logic [7:0]        i_char,
    output dmsp_pkg::t_result o_result
);
    import dmsp_pkg::*;

    t_phase                r_phase, n_phase;
    logic                  r_first, n_first;
    logic                  r_sign, n_sign;
    logic [FIELD_BITS-1:0] r_deg, n_deg;
    logic [FIELD_BITS-1:0] r_min, n_min;
    logic [FIELD_BITS-1:0] r_sec, n_sec;
    logic [29:0]           r_frac, n_frac;
    logic [3:0]            r_frac_count, n_frac_count;
    logic                  r_sat, n_sat;

    logic                  is_digit, is_sign, take, sign_take;
    logic [7:0]            char_diff;
    logic [3:0]            digit;
    logic [FIELD_BITS-1:0] acc_sel;
    logic [FIELD_BITS+3:0] acc_ext, prod;
    logic                  push_sat;
    logic [FIELD_BITS-1:0] push_val;
    logic [29:0]           frac_next;
    logic                  frac_room;

    function automatic logic [15:0] to_out(input logic [FIELD_BITS-1:0] a);
        logic [FIELD_BITS+15:0] w;
        w = {16'd0, a};
        return w[15:0];
    endfunction

    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_sign   = (i_char == CH_MINUS) || (i_char == CH_PLUS);
    assign take      = i_step_valid && (i_opcode == OP_CHAR);
    assign sign_take = take && r_first && is_sign;
    assign char_diff = i_char - CH_ZERO;
    assign digit     = char_diff[3:0];

    // one shared times-ten step for the active whole-number field
    always_comb begin
        case (r_phase)
            PH_MIN:  acc_sel = r_min;
            PH_SEC:  acc_sel = r_sec;
            default: acc_sel = r_deg;
        endcase
    end

    assign acc_ext  = {4'd0, acc_sel};
    assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{FIELD_BITS{1'b0}}, digit};
    assign push_sat = |prod[FIELD_BITS+3:FIELD_BITS];
    assign push_val = push_sat ? {FIELD_BITS{1'b1}} : prod[FIELD_BITS-1:0];

    assign frac_next = (r_frac << 3) + (r_frac << 1) + {26'd0, digit};
    assign frac_room = r_frac_count < 4'(MAX_FRAC_DIGITS);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step_valid && i_opcode == OP_END) begin
            n_phase = PH_DEG;
        end else if (take && !sign_take) begin
            unique case (r_phase)
                PH_DEG: begin
                    if (!is_digit) begin
                        n_phase = (i_char == CH_COLON || i_char == CH_D ||
                                   i_char == CH_SPACE) ? PH_MIN : PH_FAIL;
                    end
                end
                PH_MIN: begin
                    if (!is_digit) begin
                        n_phase = (i_char == CH_COLON || i_char == CH_M ||
                                   i_char == CH_SPACE) ? PH_SEC : PH_FAIL;
                    end
                end
                PH_SEC: begin
                    if (!is_digit) begin
                        if (i_char == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else if (i_char == CH_S) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                end
                PH_FRAC: begin
                    if (!is_digit) begin
                        n_phase = (i_char == CH_S) ? PH_DONE : PH_FAIL;
                    end
                end
                default: n_phase = PH_FAIL;
            endcase
        end
    end

    // accumulators and flags
    always_comb begin
        n_first      = r_first;
        n_sign       = r_sign;
        n_deg        = r_deg;
        n_min        = r_min;
        n_sec        = r_sec;
        n_frac       = r_frac;
        n_frac_count = r_frac_count;
        n_sat        = r_sat;
        if (i_step_valid && i_opcode == OP_END) begin
            n_first      = 1'b1;
            n_sign       = 1'b0;
            n_deg        = '0;
            n_min        = '0;
            n_sec        = '0;
            n_frac       = '0;
            n_frac_count = '0;
            n_sat        = 1'b0;
        end else if (take) begin
            n_first = 1'b0;
            if (sign_take) begin
                n_sign = (i_char == CH_MINUS);
            end else if (is_digit) begin
                case (r_phase)
                    PH_DEG: begin
                        n_deg = push_val;
                        n_sat = r_sat | push_sat;
                    end
                    PH_MIN: begin
                        n_min = push_val;
                        n_sat = r_sat | push_sat;
                    end
                    PH_SEC: begin
                        n_sec = push_val;
                        n_sat = r_sat | push_sat;
                    end
                    PH_FRAC: begin
                        if (frac_room) begin
                            n_frac       = frac_next;
                            n_frac_count = r_frac_count + 4'd1;
                        end else begin
                            n_sat = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_DEG;
            r_first      <= 1'b1;
            r_sign       <= 1'b0;
            r_deg        <= '0;
            r_min        <= '0;
            r_sec        <= '0;
            r_frac       <= '0;
            r_frac_count <= '0;
            r_sat        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_first      <= n_first;
            r_sign       <= n_sign;
            r_deg        <= n_deg;
            r_min        <= n_min;
            r_sec        <= n_sec;
            r_frac       <= n_frac;
            r_frac_count <= n_frac_count;
            r_sat        <= n_sat;
        end
    end

    always_comb begin
        if (r_phase == PH_FAIL) begin
            o_result = '0;
        end else begin
            o_result.valid_res       = 1'b1;
            o_result.negative        = r_sign;
            o_result.degrees         = to_out(r_deg);
            o_result.minutes         = to_out(r_min);
            o_result.seconds         = to_out(r_sec);
            o_result.fraction        = r_frac;
            o_result.fraction_digits = r_frac_count;
            o_result.overflow        = r_sat;
        end
    end

`ifndef ASSERT_OFF
    a_frac_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_count <= 4'(MAX_FRAC_DIGITS))
        else $error("fraction digit count beyond limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step_valid && i_opcode == OP_END |=> r_phase == PH_DEG && r_first && !r_sat)
        else $error("end beat did not return parser to start");

    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FAIL && !(i_step_valid && i_opcode == OP_END) |=> r_phase == PH_FAIL)
        else $error("failed parse left failed phase before end");
`endif

endmodule

// ----- rtl/dms_angle_text_parser.sv -----
// Top level of the DMS angle text parser: input register, parser core, result register.
// Flow: an accepted beat is held in the input register and processed by the core from
//   there; an end beat loads the core's result into the result register for o_out.
// Throughput: one beat per cycle; only an end beat waits, for a free result register.
// The character step is one times-ten add and compare on the active field.
// Reset (synchronous, active low) empties both registers and returns the parser to start.
`timescale 1ns / 1ps

module dms_angle_text_parser #(
    parameter int FIELD_BITS      = 16,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dmsp_in_if.sink           i_in,
    dmsp_out_if.source        o_out
);
    import dmsp_pkg::*;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    t_result    r_res;
    t_result    core_res;
    logic       out_free;
    logic       proceed;

    assign out_free    = !r_out_valid || o_out.ready;
    assign proceed     = r_in_valid && (r_in_op == OP_CHAR || out_free);
    assign i_in.ready  = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op   <= i_in.opcode;
            r_in_char <= i_in.char_code;
        end
    end

    dmsp_core #(
        .FIELD_BITS      (FIELD_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (proceed),
        .i_opcode     (r_in_op),
        .i_char       (r_in_char),
        .o_result     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && r_in_op == OP_END) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && r_in_op == OP_END) begin
            r_res <= core_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.valid_res       = r_res.valid_res;
    assign o_out.negative        = r_res.negative;
    assign o_out.degrees         = r_res.degrees;
    assign o_out.minutes         = r_res.minutes;
    assign o_out.seconds         = r_res.seconds;
    assign o_out.fraction        = r_res.fraction;
    assign o_out.fraction_digits = r_res.fraction_digits;
    assign o_out.overflow        = r_res.overflow;

`ifndef ASSERT_OFF
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.valid_res |-> r_res.negative == 1'b0 &&
        r_res.degrees == '0 && r_res.minutes == '0 && r_res.seconds == '0 &&
        r_res.fraction == '0 && r_res.fraction_digits == '0 && !r_res.overflow)
        else $error("failed parse result carries nonzero fields");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_in_op == OP_END && r_out_valid)
        else $error("input stalled without a blocked end beat");

    a_end_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && r_in_op == OP_END |=> r_out_valid)
        else $error("end beat produced no result");

    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res.fraction_digits <= 4'(MAX_FRAC_DIGITS))
        else $error("result fraction digit count beyond limit");
`endif

endmodule

// ----- verif/tb.sv -----
// Testbench for dms_angle_text_parser: directed and random angle texts checked against a parser model.
`timescale 1ns / 1ps

module tb;
    import dmsp_pkg::*;

    localparam int FIELD_MAX     = 65535;
    localparam int FRAC_KEEP     = 9;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 150;

    logic i_clk;
    logic i_rst_n;

    dmsp_in_if  in_if();
    dmsp_out_if out_if();

    dms_angle_text_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // parser model state
    t_phase      ph = PH_DEG;
    logic        first_ch = 1'b1;
    logic        neg = 1'b0;
    int          deg_v = 0;
    int          min_v = 0;
    int          sec_v = 0;
    logic [29:0] frac_v = '0;
    int          frac_n = 0;
    logic        sat_v = 1'b0;

    t_result     pending_angles[$];
    logic [7:0]  text_buf[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_hold_left = 0;

    int n_errors = 0;
    int n_beats = 0;
    int n_chars = 0;
    int n_texts = 0;
    int n_good = 0;
    int n_rejected = 0;
    int n_sat = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("FAIL dms_angle_text_parser");
        $finish;
    end

    function automatic void clear_parser();
        ph       = PH_DEG;
        first_ch = 1'b1;
        neg      = 1'b0;
        deg_v    = 0;
        min_v    = 0;
        sec_v    = 0;
        frac_v   = '0;
        frac_n   = 0;
        sat_v    = 1'b0;
    endfunction

    function automatic int add_digit(input int acc, input int d);
        int v;
        v = acc * 10 + d;
        if (v > FIELD_MAX) begin
            sat_v = 1'b1;
            return FIELD_MAX;
        end
        return v;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic was_first;
        logic is_dig;
        int   d;
        was_first = first_ch;
        first_ch  = 1'b0;
        is_dig    = (c >= CH_ZERO) && (c <= CH_NINE);
        d         = int'(c) - int'(CH_ZERO);
        if (was_first && (c == CH_MINUS || c == CH_PLUS)) begin
            neg = (c == CH_MINUS);
            return;
        end
        case (ph)
            PH_DEG: begin
                if (is_dig) deg_v = add_digit(deg_v, d);
                else if (c == CH_COLON || c == CH_D || c == CH_SPACE) ph = PH_MIN;
                else ph = PH_FAIL;
            end
            PH_MIN: begin
                if (is_dig) min_v = add_digit(min_v, d);
                else if (c == CH_COLON || c == CH_M || c == CH_SPACE) ph = PH_SEC;
                else ph = PH_FAIL;
            end
            PH_SEC: begin
                if (is_dig) sec_v = add_digit(sec_v, d);
                else if (c == CH_DOT) ph = PH_FRAC;
                else if (c == CH_S) ph = PH_DONE;
                else ph = PH_FAIL;
            end
            PH_FRAC: begin
                if (is_dig) begin
                    if (frac_n < FRAC_KEEP) begin
                        frac_v = 30'(int'(frac_v) * 10 + d);
                        frac_n++;
                    end else begin
                        sat_v = 1'b1;
                    end
                end else if (c == CH_S) begin
                    ph = PH_DONE;
                end else begin
                    ph = PH_FAIL;
                end
            end
            default: ph = PH_FAIL;
        endcase
    endfunction

    function automatic t_result close_text();
        t_result r;
        r = '0;
        if (ph != PH_FAIL) begin
            r.valid_res       = 1'b1;
            r.negative        = neg;
            r.degrees         = deg_v[15:0];
            r.minutes         = min_v[15:0];
            r.seconds         = sec_v[15:0];
            r.fraction        = frac_v;
            r.fraction_digits = frac_n[3:0];
            r.overflow        = sat_v;
        end
        clear_parser();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // result checking and input tracking on one edge
    always @(posedge i_clk) begin : angle_monitor
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got degrees %0d",
                         $time, out_if.degrees);
                n_errors++;
            end else begin
                want = pending_angles.pop_front();
                check_field("valid_res", 32'(want.valid_res), 32'(out_if.valid_res));
                check_field("negative", 32'(want.negative), 32'(out_if.negative));
                check_field("degrees", 32'(want.degrees), 32'(out_if.degrees));
                check_field("minutes", 32'(want.minutes), 32'(out_if.minutes));
                check_field("seconds", 32'(want.seconds), 32'(out_if.seconds));
                check_field("fraction", 32'(want.fraction), 32'(out_if.fraction));
                check_field("fraction_digits", 32'(want.fraction_digits),
                            32'(out_if.fraction_digits));
                check_field("overflow", 32'(want.overflow), 32'(out_if.overflow));
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            if (in_if.opcode == OP_CHAR) begin
                parse_char(in_if.char_code);
                n_chars++;
            end else begin
                want = close_text();
                pending_angles.push_back(want);
                n_texts++;
                if (!want.valid_res) n_rejected++;
                else n_good++;
                if (want.overflow) n_sat++;
            end
        end
    end

    // receiver ready, with the long hold counted down here
    always @(posedge i_clk) begin : recv_ready
        if (stall_hold_left > 0) begin
            stall_hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.opcode    <= op;
        in_if.char_code <= ch;
        do @(posedge i_clk); while (!in_if.ready);
        n_beats++;
    endtask

    task automatic send_buf();
        foreach (text_buf[i]) send_beat(OP_CHAR, text_buf[i]);
        send_beat(OP_END, 8'($urandom_range(255)));
    endtask

    task automatic load_str(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_angles.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(posedge i_clk);
    endtask

    function automatic int rand_len();
        return ($urandom_range(99) < 10) ? $urandom_range(5, 7) : $urandom_range(0, 3);
    endfunction

    function automatic void add_digits(input int n);
        repeat (n) text_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void build_random_text();
        logic [7:0] deg_seps[3];
        logic [7:0] min_seps[3];
        int         cut;
        deg_seps = '{CH_COLON, CH_D, CH_SPACE};
        min_seps = '{CH_COLON, CH_M, CH_SPACE};
        text_buf.delete();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(8)) text_buf.push_back(8'($urandom_range(255)));
            return;
        end
        case ($urandom_range(3))
            0: text_buf.push_back(CH_MINUS);
            1: text_buf.push_back(CH_PLUS);
            default: ;
        endcase
        add_digits(rand_len());
        text_buf.push_back(deg_seps[$urandom_range(2)]);
        add_digits(rand_len());
        text_buf.push_back(min_seps[$urandom_range(2)]);
        add_digits(rand_len());
        if ($urandom_range(1)) begin
            text_buf.push_back(CH_DOT);
            add_digits(($urandom_range(99) < 15) ? $urandom_range(10, 13) : $urandom_range(6));
        end
        if ($urandom_range(1)) text_buf.push_back(CH_S);
        if ($urandom_range(99) < 12) begin
            cut = $urandom_range(text_buf.size());
            while (text_buf.size() > cut) void'(text_buf.pop_back());
        end
        if ($urandom_range(99) < 12)
            text_buf.insert($urandom_range(text_buf.size()), 8'($urandom_range(255)));
        if ($urandom_range(99) < 5) text_buf.push_back(8'($urandom_range(255)));
    endfunction

    task automatic test_directed();
        string cases[18];
        cases = '{"", "-", "+12d34m56.789s", "-0:0:0", "359 59 59.999999999",
                  "1:2:3.1234567890123s", "99999d", "1:99999:0", "1:2:65536",
                  "65535:65535:65535s", "1:2:3s4", "1:2:3ss", "1-2", "--5", "12x",
                  "1:2.5", "1:2:3. ", "12d"};
        set_idling(0, 0);
        foreach (cases[i]) begin
            load_str(cases[i]);
            send_buf();
        end
        load_str("1");
        text_buf.push_back(8'hFF);
        send_buf();
        load_str("");
        text_buf.push_back(8'h00);
        send_buf();
        wait_drained();
    endtask

    task automatic test_random_texts(input int send_pct, input int recv_pct, input int beats);
        int stop_at;
        stop_at = n_beats + beats;
        set_idling(send_pct, recv_pct);
        while (n_beats < stop_at) begin
            build_random_text();
            send_buf();
        end
        wait_drained();
    endtask

    // receiver holds off while short texts keep coming, so end beats back up into the input
    task automatic test_backpressure();
        set_idling(0, 0);
        @(negedge i_clk);
        stall_hold_left = LONG_HOLD;
        @(posedge i_clk);
        repeat (30) begin
            text_buf.delete();
            add_digits($urandom_range(2));
            send_buf();
        end
        wait_drained();
    endtask

    initial begin
        in_if.valid     <= 1'b0;
        in_if.opcode    <= OP_CHAR;
        in_if.char_code <= '0;
        i_rst_n         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_texts(0, 0, 55);
        test_random_texts(80, 0, 55);
        test_random_texts(0, 80, 55);
        test_random_texts(33, 33, 55);
        test_backpressure();

        $display("Parsed %0d texts over %0d beats (%0d characters)", n_texts, n_beats, n_chars);
        $display("  %0d well-formed, %0d rejected, %0d saturated or truncated",
                 n_good, n_rejected, n_sat);
        if (n_errors == 0) begin
            $display("PASS dms_angle_text_parser");
        end else begin
            $display("FAIL dms_angle_text_parser");
        end
        $finish;
    end

endmodule
